### rtl/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants of the bounded deque: request and status codes,
// and the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package bdq_pkg;

   // Default number of storage slots.
   localparam int DEPTH_DEFAULT = 16;

   // Width of the entry count and of the capacity register.
   localparam int COUNT_W = 5;

   // Capacity after reset.
   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 5'd16;

   // Width of the configuration address bus; register i sits at byte 4*i.
   localparam int CSR_AW = 3;

   // Register index of the capacity register.
   localparam logic CSR_CAPACITY = 1'b0;

   // Request codes.
   typedef enum logic [2:0] {
      REQ_PUSH_BACK  = 3'd0,
      REQ_PUSH_FRONT = 3'd1,
      REQ_POP_FRONT  = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_REMOVE     = 3'd4
   } req_code_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Address choice for the first memory read port.
   typedef enum logic [1:0] {
      RD_FRONT,
      RD_BACK,
      RD_SCAN,
      RD_SHIFT
   } rd_sel_type;

   // Address choice for the memory write port.
   typedef enum logic [1:0] {
      WR_BACK,
      WR_FRONT,
      WR_SHIFT
   } wr_sel_type;

   // Pointer and count updates.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_PUSH_BACK,
      OP_PUSH_FRONT,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_REMOVE
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       latch;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      op_type     op;
      logic       idx_clr;
      logic       idx_inc;
      logic       capture_pop;
      logic       set_status;
      status_type status;
      logic       respond;
   } dp_cmd_type;

   // Status flags from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic idx_end;
      logic idx_last;
      logic match;
   } dp_stat_type;

endpackage

### rtl/bounded_deque_with_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_remove
// Double-ended queue of signed 32-bit values in a circular buffer, with a
// configurable capacity and a remove-first-match request.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   request   start / busy            req_type, req_data_in
//   result    rsp_valid (one cycle)   rsp_status, rsp_data_out, rsp_entry_count,
//                                     rsp_front_value, rsp_back_value
//   config    APB psel/penable        paddr, pwdata, prdata (capacity at 0)
//
// Each transaction steps through the issue, execute, fetch and reply states;
// busy holds off a new request until the result strobe. A remove scans from
// the front, reading and comparing one entry at a time, then moves each
// later entry one slot toward the front. The entry memory has a single write
// port and registered reads. Reset clears pointers, count and capacity at once;
// no clearing pass is needed. The receiver cannot stall the result strobe.
//
module bounded_deque_with_remove
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_type,
   input  logic signed [31:0]   req_data_in,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic signed [31:0]   rsp_data_out,
   output logic [COUNT_W-1:0]   rsp_entry_count,
   output logic signed [31:0]   rsp_front_value,
   output logic signed [31:0]   rsp_back_value,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [CSR_AW-1:0]    paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   logic [COUNT_W-1:0] capacity_ff;
   logic               csr_write;
   dp_cmd_type         cmd;
   dp_stat_type        stat;

   // Configuration register, written in the access phase.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == CSR_CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_write) begin
         capacity_ff <= pwdata[COUNT_W-1:0];
      end
   end

   assign prdata = (paddr[2] == CSR_CAPACITY) ? {{(32-COUNT_W){1'b0}}, capacity_ff} : '0;

   bdq_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   bdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_data_in     (req_data_in),
      .capacity        (capacity_ff),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value)
   );

endmodule

### rtl/bdq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_datapath
// Entry memory, front pointer, entry count, scan index and result registers
// of the bounded deque. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module bdq_datapath
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [31:0]        req_data_in,
   input  logic [COUNT_W-1:0]        capacity,
   input  dp_cmd_type                cmd,
   output dp_stat_type               stat,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic signed [31:0]        rsp_data_out,
   output logic [COUNT_W-1:0]        rsp_entry_count,
   output logic signed [31:0]        rsp_front_value,
   output logic signed [31:0]        rsp_back_value
);

   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW      = ((AW > COUNT_W) ? AW : COUNT_W) + 1;
   localparam int LIM_MAX = (DEPTH < (1 << COUNT_W) - 1) ? DEPTH : (1 << COUNT_W) - 1;
   localparam logic [COUNT_W-1:0] LIM_MAX_C = COUNT_W'(LIM_MAX);
   localparam logic [AW-1:0]      LAST_SLOT = AW'(DEPTH - 1);

   // Slot of the entry at a given distance from the front, wrapped once.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [COUNT_W-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   logic signed [31:0]  mem [DEPTH];

   logic [AW-1:0]       front_ff, front_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  idx_ff;
   logic signed [31:0]  data_ff;
   logic signed [31:0]  pop_ff;
   status_type          status_ff;
   logic signed [31:0]  rd_a_ff, rd_b_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic signed [31:0]  rsp_data_ff, rsp_front_ff, rsp_back_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic [COUNT_W-1:0]  limit;
   logic [COUNT_W-1:0]  idx_next;
   logic [AW-1:0]       front_dec, front_inc, back_slot;
   logic [AW-1:0]       rd_addr_a, wr_addr;
   logic signed [31:0]  wr_data;

   // Effective capacity, saturated to the built depth.
   assign limit    = (capacity > LIM_MAX_C) ? LIM_MAX_C : capacity;
   assign idx_next = idx_ff + 1'b1;

   // Neighbor slots of the front pointer and the slot of the back entry.
   assign front_dec = (front_ff == '0) ? LAST_SLOT : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST_SLOT) ? '0 : front_ff + 1'b1;
   assign back_slot = (count_ff == '0) ? front_ff : slot_of(front_ff, count_ff - 1'b1);

   // Status flags for the controller.
   assign stat.full     = (count_ff >= limit);
   assign stat.empty    = (count_ff == '0);
   assign stat.idx_end  = (idx_ff >= count_ff);
   assign stat.idx_last = (idx_next >= count_ff);
   assign stat.match    = (rd_a_ff == data_ff);

   // Read and write address selection.
   always_comb begin
      unique case (cmd.rd_sel)
         RD_FRONT: rd_addr_a = front_ff;
         RD_BACK:  rd_addr_a = back_slot;
         RD_SCAN:  rd_addr_a = slot_of(front_ff, idx_ff);
         RD_SHIFT: rd_addr_a = slot_of(front_ff, idx_next);
         default:  rd_addr_a = front_ff;
      endcase
      unique case (cmd.wr_sel)
         WR_BACK:  wr_addr = slot_of(front_ff, count_ff);
         WR_FRONT: wr_addr = front_dec;
         WR_SHIFT: wr_addr = slot_of(front_ff, idx_ff);
         default:  wr_addr = front_ff;
      endcase
      wr_data = (cmd.wr_sel == WR_SHIFT) ? rd_a_ff : data_ff;
   end

   // Entry memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[back_slot];
   end

   // Pointer and count updates.
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_PUSH_BACK: begin
            count_in = count_ff + 1'b1;
         end
         OP_PUSH_FRONT: begin
            front_in = front_dec;
            count_in = count_ff + 1'b1;
         end
         OP_POP_FRONT: begin
            front_in = front_inc;
            count_in = count_ff - 1'b1;
         end
         OP_POP_BACK, OP_REMOVE: begin
            count_in = count_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   // Transaction payload, scan index and partial result.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         data_ff   <= req_data_in;
         pop_ff    <= '0;
         status_ff <= ST_OK;
      end else begin
         if (cmd.capture_pop) begin
            pop_ff <= rd_a_ff;
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
      end
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_next;
      end
   end

   // Result registers, loaded once per transaction.
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= pop_ff;
         rsp_count_ff  <= count_ff;
         rsp_front_ff  <= (count_ff == '0) ? '0 : rd_a_ff;
         rsp_back_ff   <= (count_ff == '0) ? '0 : rd_b_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;

endmodule

### rtl/bdq_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_controller
// Sequencer of the bounded deque. Steps each transaction through its memory
// reads and writes, the remove scan and shift, and the result cycle.
// ----------------------------------------------------------------------------
module bdq_controller
   import bdq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  req_type,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        busy
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ISSUE,
      S_EXEC,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FETCH,
      S_REPLY
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  req_ff;
   logic        busy_ff;
   logic        accept;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.rd_sel      = RD_FRONT;
      cmd.wr_sel      = WR_BACK;
      cmd.op          = OP_NONE;
      cmd.status      = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               state_in  = S_ISSUE;
            end
         end
         // Read the entry a pop will return.
         S_ISSUE: begin
            cmd.rd_sel  = (req_code_type'(req_ff) == REQ_POP_BACK) ? RD_BACK : RD_FRONT;
            cmd.idx_clr = 1'b1;
            state_in    = S_EXEC;
         end
         // Carry out push and pop, or start the remove scan.
         S_EXEC: begin
            state_in = S_FETCH;
            unique case (req_code_type'(req_ff))
               REQ_PUSH_BACK: begin
                  if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = WR_BACK;
                     cmd.op     = OP_PUSH_BACK;
                  end
               end
               REQ_PUSH_FRONT: begin
                  if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = WR_FRONT;
                     cmd.op     = OP_PUSH_FRONT;
                  end
               end
               REQ_POP_FRONT: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else begin
                     cmd.capture_pop = 1'b1;
                     cmd.op          = OP_POP_FRONT;
                  end
               end
               REQ_POP_BACK: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else begin
                     cmd.capture_pop = 1'b1;
                     cmd.op          = OP_POP_BACK;
                  end
               end
               REQ_REMOVE: begin
                  state_in = S_SCAN_RD;
               end
               default: begin
               end
            endcase
         end
         // Read the next entry of the scan, or give up past the back.
         S_SCAN_RD: begin
            if (stat.idx_end) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NOT_FOUND;
               state_in       = S_FETCH;
            end else begin
               cmd.rd_sel = RD_SCAN;
               state_in   = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (stat.match) begin
               state_in = S_SHIFT_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         // Move each later entry one slot toward the front.
         S_SHIFT_RD: begin
            if (stat.idx_last) begin
               cmd.op   = OP_REMOVE;
               state_in = S_FETCH;
            end else begin
               cmd.rd_sel = RD_SHIFT;
               state_in   = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_SHIFT;
            cmd.idx_inc = 1'b1;
            state_in    = S_SHIFT_RD;
         end
         // Read the front and back entries for the result.
         S_FETCH: begin
            cmd.rd_sel = RD_FRONT;
            state_in   = S_REPLY;
         end
         S_REPLY: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, busy flag and the latched request code.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
      if (accept) begin
         req_ff <= req_type;
      end
   end

endmodule

### rtl/bdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks of the bounded deque, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bdq_checker
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [1:0]          rsp_status,
   input logic [COUNT_W-1:0]  rsp_entry_count,
   input logic signed [31:0]  rsp_front_value,
   input logic signed [31:0]  rsp_back_value
);

   // An accepted transaction makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   // Each result strobe lasts exactly one cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // An empty queue reports zero front and back values.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_entry_count == '0) |-> (rsp_front_value == '0) && (rsp_back_value == '0))
      else $error("empty queue reported nonzero front or back");

   // An empty status only comes from an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_entry_count == '0))
      else $error("empty status with entries held");

   // The count never exceeds the built depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_entry_count) <= DEPTH))
      else $error("entry count above depth");

endmodule

bind bounded_deque_with_remove bdq_checker #(
   .DEPTH (DEPTH)
) u_bdq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count),
   .rsp_front_value (rsp_front_value),
   .rsp_back_value  (rsp_back_value)
);
